// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/hsvg_pkg.sv =====
// ---------------------------------------------------------------------------
// hsvg_pkg
// Shared types, constants and helper functions of the HSV gain pixel block.
// ---------------------------------------------------------------------------
package hsvg_pkg;

	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int GAIN_W             = 16;
	localparam int PIX_W              = 8;
	localparam int CFG_IDX_W          = 2;
	localparam int QDEPTH             = 4;
	localparam int QPTR_W             = $clog2(QDEPTH);
	localparam int QCNT_W             = $clog2(QDEPTH + 1);
	localparam int DIV_STAGES         = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VAL_GAIN = 2'd1;

	// Sector holding the maximum component
	typedef enum logic [1:0] {
		SECT_R,
		SECT_G,
		SECT_B
	} sector_t;

	// Hue region of sixty degrees each
	typedef enum logic [2:0] {
		SEG_0,
		SEG_1,
		SEG_2,
		SEG_3,
		SEG_4,
		SEG_5
	} region_t;

	// One classified pixel, front to back
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] mx;
		logic [7:0] d;
		logic [7:0] mag;
		logic       neg;
		sector_t    sect;
		logic       bypass;
	} pix_req_t;

	// Queue status toward the top level
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} q_stat_t;

	// Scale an offset below sixty to a 0..255 fraction: floor(x * 256 / 60)
	function automatic logic [7:0] rem_scale(input logic [5:0] x);
		logic [18:0] prod;
		prod = 19'(x) * 19'd4370;
		return prod[17:10];
	endfunction

endpackage

// ===== rtl/hsvg_front.sv =====
// ---------------------------------------------------------------------------
// hsvg_front
// Classifies an incoming pixel: max, min spread, hue sector and bypass.
// ---------------------------------------------------------------------------
module hsvg_front import hsvg_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic [7:0]        red_in,
	input  logic [7:0]        green_in,
	input  logic [7:0]        blue_in,
	input  logic [GAIN_W-1:0] sat_gain,
	input  logic [GAIN_W-1:0] val_gain,
	output pix_req_t          req
);

	localparam logic [GAIN_W:0] UNITY = (GAIN_W+1)'(1) << GAIN_FRAC_BITS;

	logic [7:0] mn;
	logic [7:0] mx;
	logic [8:0] diff;

	// Find extremes
	always_comb begin
		mn = (red_in < green_in) ? ((red_in < blue_in) ? red_in : blue_in)
		                         : ((green_in < blue_in) ? green_in : blue_in);
		mx = (red_in > green_in) ? ((red_in > blue_in) ? red_in : blue_in)
		                         : ((green_in > blue_in) ? green_in : blue_in);
	end

	// Pick sector and signed hue numerator
	always_comb begin
		if (mx == red_in) begin
			req.sect = SECT_R;
			diff     = {1'b0, green_in} - {1'b0, blue_in};
		end else if (mx == green_in) begin
			req.sect = SECT_G;
			diff     = {1'b0, blue_in} - {1'b0, red_in};
		end else begin
			req.sect = SECT_B;
			diff     = {1'b0, red_in} - {1'b0, green_in};
		end
		req.neg    = diff[8];
		req.mag    = diff[8] ? 8'(-diff) : diff[7:0];
		req.r      = red_in;
		req.g      = green_in;
		req.b      = blue_in;
		req.mx     = mx;
		req.d      = mx - mn;
		req.bypass = ({1'b0, sat_gain} == UNITY) && ({1'b0, val_gain} == UNITY);
	end

endmodule

// ===== rtl/hsvg_queue.sv =====
// ---------------------------------------------------------------------------
// hsvg_queue
// Short request queue decoupling the classifier from the conversion pipe.
// ---------------------------------------------------------------------------
module hsvg_queue import hsvg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pix_req_t push_data,
	input  logic     pop,
	output pix_req_t head,
	output q_stat_t  stat
);

	pix_req_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Store requests
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// ===== rtl/hsvg_back.sv =====
// ---------------------------------------------------------------------------
// hsvg_back
// Conversion pipe: divides for saturation and hue, applies gains, rebuilds RGB.
// ---------------------------------------------------------------------------
module hsvg_back import hsvg_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  pix_req_t          head,
	output logic              pop,
	input  logic [GAIN_W-1:0] sat_gain,
	input  logic [GAIN_W-1:0] val_gain,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out
);

	localparam int PROD_W = PIX_W + GAIN_W;

	typedef struct packed {
		pix_req_t    ctx;
		logic [15:0] srem;
		logic [7:0]  sq;
		logic [15:0] hrem;
		logic [7:0]  hq;
	} div_t;

	logic adv;
	div_t div_seed;
	div_t div_in [DIV_STAGES];
	div_t div_nx [DIV_STAGES];
	div_t div_s  [DIV_STAGES];
	logic vld_s  [DIV_STAGES];

	// Whole pipe moves unless the result waits
	assign adv = !out_valid || !out_stall;
	assign pop = head_valid && adv;

	// Seed the dividers from the queue head
	always_comb begin
		div_seed.ctx  = head;
		div_seed.srem = {head.d, 8'd0} - 16'(head.d);
		div_seed.sq   = '0;
		div_seed.hrem = 16'(head.mag) * 16'd60;
		div_seed.hq   = '0;
	end

	// One quotient bit per stage, both divisions side by side
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		localparam int K = DIV_STAGES - 1 - i;
		if (i > 0) begin : g_link
			assign div_in[i] = div_s[i-1];
		end else begin : g_first
			assign div_in[i] = div_seed;
		end
		always_comb begin
			logic [15:0] sden;
			logic [15:0] hden;
			sden      = 16'(div_in[i].ctx.mx) << K;
			hden      = 16'(div_in[i].ctx.d) << K;
			div_nx[i] = div_in[i];
			if (div_in[i].srem >= sden) begin
				div_nx[i].srem  = div_in[i].srem - sden;
				div_nx[i].sq[K] = 1'b1;
			end
			if (div_in[i].hrem >= hden) begin
				div_nx[i].hrem  = div_in[i].hrem - hden;
				div_nx[i].hq[K] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[i] <= div_nx[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= (i == 0) ? head_valid : vld_s[i-((i > 0) ? 1 : 0)];
			end
		end
	end

	// Stage 9: hue from sector, gains on saturation and value
	div_t        dv;
	logic [9:0]  hue_c;
	logic [7:0]  sat_c;
	logic [PROD_W-1:0] sprod, vprod, ssh, vsh;
	logic        vld_s9, byp_s9;
	logic [23:0] rgb_s9;
	logic [8:0]  hue_s9;
	logic [7:0]  sat_s9, val_s9;

	assign dv = div_s[DIV_STAGES-1];

	always_comb begin
		logic [9:0] off;
		off = dv.ctx.neg ? (10'd0 - 10'(dv.hq)) : 10'(dv.hq);
		case (dv.ctx.sect)
			SECT_R: begin
				hue_c = 10'd360 + off;
				if (hue_c > 10'd359) begin
					hue_c = hue_c - 10'd360;
				end
			end
			SECT_G: hue_c = 10'd120 + off;
			default: hue_c = 10'd240 + off;
		endcase
		sat_c = (dv.ctx.mx == 8'd0) ? 8'd0 : dv.sq;
		sprod = PROD_W'(sat_c) * PROD_W'(sat_gain);
		vprod = PROD_W'(dv.ctx.mx) * PROD_W'(val_gain);
		ssh   = sprod >> GAIN_FRAC_BITS;
		vsh   = vprod >> GAIN_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byp_s9 <= dv.ctx.bypass;
			rgb_s9 <= {dv.ctx.r, dv.ctx.g, dv.ctx.b};
			hue_s9 <= hue_c[8:0];
			sat_s9 <= (|ssh[PROD_W-1:8]) ? 8'hFF : ssh[7:0];
			val_s9 <= (|vsh[PROD_W-1:8]) ? 8'hFF : vsh[7:0];
		end
	end

	// Stage 10: region, fraction and p
	region_t    reg_c;
	logic [8:0] base_c;
	logic [15:0] p_prod;
	logic       vld_s10, byp_s10;
	logic [23:0] rgb_s10;
	logic [7:0] sat_s10, val_s10, rem_s10, p_s10;
	region_t    reg_s10;

	always_comb begin
		if (hue_s9 >= 9'd300) begin
			reg_c = SEG_5; base_c = 9'd300;
		end else if (hue_s9 >= 9'd240) begin
			reg_c = SEG_4; base_c = 9'd240;
		end else if (hue_s9 >= 9'd180) begin
			reg_c = SEG_3; base_c = 9'd180;
		end else if (hue_s9 >= 9'd120) begin
			reg_c = SEG_2; base_c = 9'd120;
		end else if (hue_s9 >= 9'd60) begin
			reg_c = SEG_1; base_c = 9'd60;
		end else begin
			reg_c = SEG_0; base_c = 9'd0;
		end
		p_prod = 16'(val_s9) * 16'(8'd255 - sat_s9);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byp_s10 <= byp_s9;
			rgb_s10 <= rgb_s9;
			sat_s10 <= sat_s9;
			val_s10 <= val_s9;
			reg_s10 <= reg_c;
			rem_s10 <= rem_scale(6'(hue_s9 - base_c));
			p_s10   <= p_prod[15:8];
		end
	end

	// Stage 11: saturation times fraction and its complement
	logic [15:0] sr_prod, srn_prod;
	logic        vld_s11, byp_s11;
	logic [23:0] rgb_s11;
	logic [7:0]  sat_s11, val_s11, p_s11, sr_s11, srn_s11;
	region_t     reg_s11;

	assign sr_prod  = 16'(sat_s10) * 16'(rem_s10);
	assign srn_prod = 16'(sat_s10) * 16'(8'd255 - rem_s10);

	always_ff @(posedge clk) begin
		if (adv) begin
			byp_s11 <= byp_s10;
			rgb_s11 <= rgb_s10;
			sat_s11 <= sat_s10;
			val_s11 <= val_s10;
			reg_s11 <= reg_s10;
			p_s11   <= p_s10;
			sr_s11  <= sr_prod[15:8];
			srn_s11 <= srn_prod[15:8];
		end
	end

	// Stage 12: q and t, then pick the region's order
	logic [15:0] q_prod, t_prod;
	logic [7:0]  q_c, t_c, ro_c, go_c, bo_c;
	logic        vld_s12;
	logic [7:0]  ro_s12, go_s12, bo_s12;

	always_comb begin
		q_prod = 16'(val_s11) * 16'(8'd255 - sr_s11);
		t_prod = 16'(val_s11) * 16'(8'd255 - srn_s11);
		q_c    = q_prod[15:8];
		t_c    = t_prod[15:8];
		if (byp_s11) begin
			{ro_c, go_c, bo_c} = rgb_s11;
		end else if (sat_s11 == 8'd0) begin
			{ro_c, go_c, bo_c} = {val_s11, val_s11, val_s11};
		end else begin
			case (reg_s11)
				SEG_0:   {ro_c, go_c, bo_c} = {val_s11, t_c, p_s11};
				SEG_1:   {ro_c, go_c, bo_c} = {q_c, val_s11, p_s11};
				SEG_2:   {ro_c, go_c, bo_c} = {p_s11, val_s11, t_c};
				SEG_3:   {ro_c, go_c, bo_c} = {p_s11, q_c, val_s11};
				SEG_4:   {ro_c, go_c, bo_c} = {t_c, p_s11, val_s11};
				default: {ro_c, go_c, bo_c} = {val_s11, p_s11, q_c};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ro_s12 <= ro_c;
			go_s12 <= go_c;
			bo_s12 <= bo_c;
		end
	end

	// Valid flags of the tail stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s9  <= vld_s[DIV_STAGES-1];
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	assign out_valid = vld_s12;
	assign red_out   = ro_s12;
	assign green_out = go_s12;
	assign blue_out  = bo_s12;

endmodule

// ===== rtl/hsv_gain_pixel_transform.sv =====
// ---------------------------------------------------------------------------
// hsv_gain_pixel_transform
// RGB pixel saturation and value gain through an integer HSV round trip.
// ---------------------------------------------------------------------------
// Input channel: in_valid with red_in, green_in, blue_in; the block raises
// in_stall when its four-entry request queue is full. Output channel:
// out_valid with red_out, green_out, blue_out; downstream holds out_stall to
// keep the result. Configuration: cfg_valid, cfg_index, cfg_data, with
// cfg_ready always high; index 0 is the saturation gain, index 1 the value
// gain (unsigned, GAIN_FRAC_BITS fraction bits), other indexes are dropped.
// Write gains only while no pixel is in flight.
// From input accept to out_valid a pixel passes the queue, the eight
// side-by-side restoring divider stages (one quotient bit per stage) and
// the stages for gain, region and the p/q/t multiplies. Throughput is one
// pixel per clock while out_stall is low; the divider pipe sets the depth.
// A stalled output freezes the whole conversion pipe; the queue keeps
// accepting until full. Reset empties the queue and pipe and sets both
// gains to 256, which is 1.0 at the default eight fraction bits, so pixels
// then pass through unchanged.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_gain_pixel_transform import hsvg_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	logic [GAIN_W-1:0] sat_gain_q;
	logic [GAIN_W-1:0] val_gain_q;
	pix_req_t          req;
	pix_req_t          head;
	q_stat_t           q_stat;
	logic              push;
	logic              pop;

	// Gain registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_gain_q <= GAIN_RESET;
			val_gain_q <= GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SAT_GAIN) begin
				sat_gain_q <= cfg_data;
			end else if (cfg_index == CFG_VAL_GAIN) begin
				val_gain_q <= cfg_data;
			end
		end
	end

	// Classify and enqueue requests
	hsvg_front #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_front (
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.sat_gain (sat_gain_q),
		.val_gain (val_gain_q),
		.req      (req)
	);

	assign in_stall = q_stat.full;
	assign push     = in_valid && !in_stall;

	hsvg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (req),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// Convert and deliver
	hsvg_back #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_stat.empty),
		.head       (head),
		.pop        (pop),
		.sat_gain   (sat_gain_q),
		.val_gain   (val_gain_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out)
	);

	`ASSERT_NEVER(a_q_over, clk, arst_n, q_stat.count > QCNT_W'(QDEPTH), "queue overfilled")
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_stat.empty, "pop from empty queue")
	`ASSERT_NEXT(a_hold_full, clk, arst_n, q_stat.full && !pop, q_stat.full, "full queue drained without pop")
	`ASSERT_IMPL(a_pop_adv, clk, arst_n, !q_stat.empty && !out_valid, pop, "idle pipe failed to pop")

endmodule

// ===== test/hsv_gain_pixel_transform_tb.sv =====
// ---------------------------------------------------------------------------
// HSV gain pixel transform testbench
// Drives RGB pixels through the saturation/value gain block under random
// idling on both channels, predicts every corrected pixel with an in-bench
// integer HSV round trip and compares each result against the oldest
// prediction. Gains are reprogrammed between phases while the block is idle.
// ---------------------------------------------------------------------------
module hsv_gain_pixel_transform_tb import hsvg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC      = GAIN_FRAC_BITS_DEF;
	localparam int DRAIN     = 40;
	localparam int IDLE_MAX  = 20000;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] red_in, green_in, blue_in;
	logic out_valid;
	logic out_stall;
	logic [7:0] red_out, green_out, blue_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0] cfg_data;

	rgb_t pixels_due[$];
	logic [15:0] sat_gain_m;
	logic [15:0] val_gain_m;
	int mismatches;
	int idle_cycles;
	int send_idle_pct;
	int recv_idle_pct;

	hsv_gain_pixel_transform dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Saturating fixed-point gain
	function automatic logic [7:0] scale_by_gain(input logic [7:0] x, input logic [15:0] gain);
		logic [31:0] prod;
		prod = (32'(x) * 32'(gain)) >> FRAC;
		return (prod > 255) ? 8'd255 : prod[7:0];
	endfunction

	// Corrected pixel for the current gains
	function automatic rgb_t correct_pixel(input rgb_t px);
		int r, g, b, mn, mx, d, hue, sat, val, h, num, mag, qt;
		int region, rem, p, q, t;
		rgb_t res;
		r = px.r;
		g = px.g;
		b = px.b;
		hue = 0;
		sat = 0;
		if (sat_gain_m == (1 << FRAC) && val_gain_m == (1 << FRAC))
			return px;
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		val = mx;
		d = mx - mn;
		if (mx != 0) begin
			sat = (255 * d) / mx;
			if (sat != 0) begin
				if (mx == r) num = g - b;
				else if (mx == g) num = b - r;
				else num = r - g;
				mag = (num < 0) ? -num : num;
				qt = (mag * 60) / d;
				if (num < 0) qt = -qt;
				if (mx == r) begin
					h = 360 + qt;
					if (h > 359) h -= 360;
				end else if (mx == g) begin
					h = 120 + qt;
				end else begin
					h = 240 + qt;
				end
				hue = h;
			end
		end
		sat = scale_by_gain(8'(sat), sat_gain_m);
		val = scale_by_gain(8'(val), val_gain_m);
		if (sat == 0) begin
			res = '{8'(val), 8'(val), 8'(val)};
		end else begin
			region = hue / 60;
			rem = ((hue - region * 60) * 256) / 60;
			p = (val * (255 - sat)) >> 8;
			q = (val * (255 - ((sat * rem) >> 8))) >> 8;
			t = (val * (255 - ((sat * (255 - rem)) >> 8))) >> 8;
			case (region)
				0: res = '{8'(val), 8'(t), 8'(p)};
				1: res = '{8'(q), 8'(val), 8'(p)};
				2: res = '{8'(p), 8'(val), 8'(t)};
				3: res = '{8'(p), 8'(q), 8'(val)};
				4: res = '{8'(t), 8'(p), 8'(val)};
				default: res = '{8'(val), 8'(p), 8'(q)};
			endcase
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (sat gain %0d, val gain %0d)",
			what, got, want, sat_gain_m, val_gain_m);
		mismatches++;
	endtask

	// Check each accepted result and drive random receiver stalls
	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					report_mismatch("unexpected pixel",
						int'({red_out, green_out, blue_out}), 0);
				end else begin
					want = pixels_due.pop_front();
					if (red_out !== want.r) report_mismatch("red", red_out, want.r);
					if (green_out !== want.g) report_mismatch("green", green_out, want.g);
					if (blue_out !== want.b) report_mismatch("blue", blue_out, want.b);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog on cycles with no accepted request
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Send one pixel, with a random gap ahead of it
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		pixels_due.push_back(correct_pixel('{r, g, b}));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Hold the input until every pixel in flight has come out
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] gain);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= gain;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SAT_GAIN) sat_gain_m = gain;
		else if (idx == CFG_VAL_GAIN) val_gain_m = gain;
	endtask

	task automatic set_gains(input logic [15:0] sg, input logic [15:0] vg);
		drain_pipe();
		write_gain(CFG_SAT_GAIN, sg);
		write_gain(CFG_VAL_GAIN, vg);
	endtask

	// Extremes, greys, every hue region and the wrap near red
	task automatic test_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd200, 8'd0);
		send_pixel(8'd100, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd200);
		send_pixel(8'd0, 8'd100, 8'd255);
		send_pixel(8'd200, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd170, 8'd85, 8'd85);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
	endtask

	task automatic test_random(input int count);
		repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Dropped index must leave both gains alone
	task automatic test_bad_index();
		drain_pipe();
		write_gain(2'd3, 16'h0000);
		write_gain(2'd2, 16'hFFFF);
		test_random(20);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		sat_gain_m = 16'd256;
		val_gain_m = 16'd256;
		send_idle_pct = 27;
		recv_idle_pct = 52;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unity gains pass pixels through
		test_directed();
		test_random(80);
		set_gains(16'd0, 16'd0);
		test_directed();
		set_gains(16'hFFFF, 16'hFFFF);
		test_directed();
		test_random(60);
		set_gains(16'd384, 16'd200);
		test_directed();
		test_random(150);
		test_bad_index();

		send_idle_pct = 52;
		recv_idle_pct = 27;
		set_gains(16'd256, 16'd300);
		test_random(150);
		set_gains(16'd128, 16'd256);
		test_random(150);
		set_gains(16'd257, 16'd255);
		test_random(100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) begin
			set_gains(16'($urandom_range(1023)), 16'($urandom_range(1023)));
			test_random(80);
		end

		drain_pipe();
		if (mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hsvg_pkg.sv
rtl/hsvg_front.sv
rtl/hsvg_queue.sv
rtl/hsvg_back.sv
rtl/hsv_gain_pixel_transform.sv
test/hsv_gain_pixel_transform_tb.sv
